@@ hw/rtl/bell_weighted_loss_accumulator_macros.svh @@
// Assertion helpers for the loss accumulator checker.
// Both sample on clk_i; the first is masked while rst_ni is low.
`ifndef BELL_WEIGHTED_LOSS_ACCUMULATOR_MACROS_SVH
`define BELL_WEIGHTED_LOSS_ACCUMULATOR_MACROS_SVH

`define BLWA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("blwa assertion failed");

`define BLWA_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("blwa reset assertion failed");

`endif

@@ hw/rtl/blwa_pkg.sv @@
`timescale 1ns / 1ps
package blwa_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned MAX_POWER_DEF  = 8;

  localparam int unsigned POWER_W   = 4;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INV_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_SCALE    = 2'd2;

  localparam logic [POWER_W-1:0] POWER_RESET = 4'd2;

  // Queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

endpackage

@@ hw/rtl/blwa_queue.sv @@
`timescale 1ns / 1ps
module blwa_queue #(
  parameter int unsigned W = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [W-1:0]     data_i,
  input  logic             pop_i,
  output logic [W-1:0]     data_o,
  output blwa_pkg::qstat_t stat_o
);
  import blwa_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign do_push = push_i && (cnt_q != DEPTH);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == DEPTH);
  assign stat_o.avail = (cnt_q != 2'd0);

endmodule

@@ hw/rtl/blwa_front.sv @@
`timescale 1ns / 1ps
module blwa_front #(
  parameter int unsigned DW = 32
) (
  input  logic signed [DW-1:0] prediction_i,
  input  logic signed [DW-1:0] label_i,
  input  logic                 last_element_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  blwa_pkg::qstat_t     q_stat_i,
  output logic                 q_push_o,
  output logic [2*DW+1:0]      q_data_o
);
  import blwa_pkg::*;

  logic [DW:0]   diff, diff_mag;
  logic [DW-1:0] lab_u, lab_mag;

  // Error in one extra bit, then split into sign and magnitude
  assign diff     = {prediction_i[DW-1], prediction_i} - {label_i[DW-1], label_i};
  assign diff_mag = diff[DW] ? (~diff + 1'b1) : diff;
  assign lab_u    = label_i;
  assign lab_mag  = lab_u[DW-1] ? (~lab_u + 1'b1) : lab_u;

  assign full_o   = q_stat_i.full;
  assign q_push_o = push_i && !q_stat_i.full;
  assign q_data_o = {last_element_i, diff[DW], diff_mag[DW-1:0], lab_mag};

endmodule

@@ hw/rtl/blwa_back.sv @@
`timescale 1ns / 1ps
module blwa_back #(
  parameter int unsigned DW = 32,
  parameter int unsigned FB = 16,
  parameter int unsigned MP = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  blwa_pkg::qstat_t              q_stat_i,
  input  logic [2*DW+1:0]               q_data_i,
  output logic                          q_pop_o,
  input  logic [DW-1:0]                 inv_threshold_i,
  input  logic [blwa_pkg::POWER_W-1:0]  power_i,
  input  logic [DW-1:0]                 gradient_scale_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [DW-1:0]                 normalized_diff_o,
  output logic [DW-1:0]                 gradient_o,
  output logic [DW-1:0]                 loss_value_o,
  output logic                          loss_valid_o
);
  import blwa_pkg::*;

  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = (PW > SUM_W) ? PW : SUM_W;
  localparam int unsigned DVW = (DW + FB > SUM_W) ? DW + FB : SUM_W;
  localparam int unsigned DSW = (DW > CNT_W + 1) ? DW : CNT_W + 1;
  localparam int unsigned CW  = $clog2(DVW + 1);
  localparam int unsigned PWW = $clog2(MP + 1);

  localparam logic [DW-1:0]    DMASK   = {DW{1'b1}};
  localparam logic [DW-1:0]    ONEQ    = {{(DW-1){1'b0}}, 1'b1} << FB;
  localparam logic [DW-1:0]    SMINMAG = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]    SMAXV   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]    SMIN1   = SMINMAG + 1'b1;
  localparam logic [DW-1:0]    QLIM    = SMINMAG >> FB;
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MA   = 3'd1;
  localparam logic [2:0] S_POW  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MG   = 3'd4;
  localparam logic [2:0] S_MT   = 3'd5;
  localparam logic [2:0] S_LDIV = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [SUM_W-1:0] mul_sat(input logic [PW-1:0] prod,
                                               input logic [SUM_W-1:0] cap);
    logic [MW-1:0] p, c;
    p = MW'(prod >> FB);
    c = MW'(cap);
    if (((prod >> SUM_W) != '0) || (p > c)) mul_sat = cap;
    else mul_sat = p[SUM_W-1:0];
  endfunction

  function automatic logic [DW-1:0] pack(input logic neg, input logic [DW-1:0] mag);
    if (neg && (mag != '0)) pack = (mag > SMINMAG) ? SMINMAG : (~mag + 1'b1);
    else pack = (mag > SMAXV) ? SMAXV : mag;
  endfunction

  function automatic logic [DW-1:0] weight(input logic [DW-1:0] acc);
    logic [DW:0] s;
    s = {1'b0, acc} + {1'b0, ONEQ};
    weight = s[DW] ? DMASK : s[DW-1:0];
  endfunction

  logic [2:0]       st_q;
  logic [CW-1:0]    cnt_q;
  logic [PWW-1:0]   k_q, pw_q, pw_cl;
  logic [DW-1:0]    em_q, a_q, dmc_q, nd_q, grad_q, loss_q;
  logic             eneg_q, last_q, dneg_q, lv_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] count_q;
  logic [PW-1:0]    ma_q, prod_q, prod_nx;
  logic [DW-1:0]    mb_q;
  logic [DVW-1:0]   dvd_q, dvd_nx;
  logic [DSW-1:0]   dsr_q, rem_q;
  logic [DSW:0]     rem_sh, rem_nx;
  logic             ge, mul_last, div_last;
  logic             ovalid_q, load_out;
  logic [DW-1:0]    o_nd_q, o_grad_q, o_loss_q;
  logic             o_lv_q;

  logic [DW-1:0]    gm, q_lo, dm, dlim, dmc, a_nx, acc_nx, gmag, lossv;
  logic             gn, qsat, dneg;
  logic [SUM_W-1:0] a_full, gmag_full;
  logic [SUM_W-1:0] term, sum_new;
  logic [CNT_W-1:0] count_new;

  // Shared shift-add multiplier and restoring divider steps
  assign prod_nx  = prod_q + (mb_q[0] ? ma_q : '0);
  assign rem_sh   = {rem_q, dvd_q[DVW-1]};
  assign ge       = rem_sh >= {1'b0, dsr_q};
  assign rem_nx   = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  assign dvd_nx   = {dvd_q[DVW-2:0], ge};
  assign mul_last = (cnt_q == CW'(DW - 1));
  assign div_last = (cnt_q == CW'(DVW - 1));

  assign pw_cl = (int'(power_i) > MP) ? PWW'(MP) : PWW'(power_i);
  assign gn    = gradient_scale_i[DW-1];
  assign gm    = gn ? (~gradient_scale_i + 1'b1) : gradient_scale_i;

  assign a_full    = mul_sat(prod_nx, SUM_W'(DMASK));
  assign a_nx      = a_full[DW-1:0];
  assign acc_nx    = a_nx;
  assign q_lo      = dvd_nx[DW-1:0];
  assign qsat      = (dvd_nx >> FB) > DVW'(QLIM);
  assign dm        = qsat ? SMIN1 : q_lo;
  assign dneg      = eneg_q && (dm != '0);
  assign dlim      = dneg ? SMINMAG : SMAXV;
  assign dmc       = (dm > dlim) ? dlim : dm;
  assign gmag_full = mul_sat(prod_nx, SUM_W'(SMIN1));
  assign gmag      = gmag_full[DW-1:0];
  assign term      = mul_sat(prod_nx, SUM_MAX);
  assign sum_new   = (sum_q > SUM_MAX - term) ? SUM_MAX : sum_q + term;
  assign count_new = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
  assign lossv     = (dvd_nx > DVW'(SMAXV)) ? SMAXV : dvd_nx[DW-1:0];

  assign q_pop_o  = (st_q == S_IDLE) && q_stat_i.avail;
  assign load_out = (st_q == S_OUT) && (!ovalid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      k_q      <= '0;
      pw_q     <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      em_q <= '0; a_q <= '0; dmc_q <= '0; nd_q <= '0; grad_q <= '0; loss_q <= '0;
      eneg_q <= 1'b0; last_q <= 1'b0; dneg_q <= 1'b0; lv_q <= 1'b0;
      ma_q <= '0; mb_q <= '0; prod_q <= '0;
      dvd_q <= '0; dsr_q <= '0; rem_q <= '0;
    end else begin
      if (load_out) ovalid_q <= 1'b1;
      else if (pop_i && ovalid_q) ovalid_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (q_stat_i.avail) begin
            last_q <= q_data_i[2*DW+1];
            eneg_q <= q_data_i[2*DW];
            em_q   <= q_data_i[2*DW-1:DW];
            pw_q   <= pw_cl;
            ma_q   <= PW'(q_data_i[DW-1:0]);
            mb_q   <= inv_threshold_i;
            prod_q <= '0;
            cnt_q  <= '0;
            st_q   <= S_MA;
          end
        end
        S_MA, S_POW, S_MG, S_MT: begin
          prod_q <= prod_nx;
          ma_q   <= ma_q << 1;
          mb_q   <= mb_q >> 1;
          cnt_q  <= cnt_q + 1'b1;
          if (mul_last) begin
            cnt_q  <= '0;
            prod_q <= '0;
            case (st_q)
              S_MA: begin
                a_q <= a_nx;
                k_q <= '0;
                if (pw_q == '0) begin
                  dvd_q <= DVW'(em_q) << FB;
                  dsr_q <= DSW'(weight(ONEQ));
                  rem_q <= '0;
                  st_q  <= S_DIV;
                end else begin
                  ma_q <= PW'(ONEQ);
                  mb_q <= a_nx;
                  st_q <= S_POW;
                end
              end
              S_POW: begin
                if (PWW'(k_q + 1'b1) == pw_q) begin
                  dvd_q <= DVW'(em_q) << FB;
                  dsr_q <= DSW'(weight(acc_nx));
                  rem_q <= '0;
                  st_q  <= S_DIV;
                end else begin
                  k_q  <= k_q + 1'b1;
                  ma_q <= PW'(acc_nx);
                  mb_q <= a_q;
                end
              end
              S_MG: begin
                grad_q <= pack(dneg_q ^ gn, gmag);
                ma_q   <= PW'(dmc_q);
                mb_q   <= em_q;
                st_q   <= S_MT;
              end
              default: begin
                count_q <= count_new;
                if (last_q) begin
                  sum_q <= sum_new;
                  dvd_q <= DVW'(sum_new);
                  dsr_q <= DSW'({count_new, 1'b0});
                  rem_q <= '0;
                  st_q  <= S_LDIV;
                end else begin
                  sum_q  <= sum_new;
                  loss_q <= '0;
                  lv_q   <= 1'b0;
                  st_q   <= S_OUT;
                end
              end
            endcase
          end
        end
        S_DIV: begin
          dvd_q <= dvd_nx;
          rem_q <= rem_nx[DSW-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            cnt_q  <= '0;
            dneg_q <= dneg;
            nd_q   <= pack(dneg, dm);
            dmc_q  <= dmc;
            ma_q   <= PW'(dmc);
            mb_q   <= gm;
            prod_q <= '0;
            st_q   <= S_MG;
          end
        end
        S_LDIV: begin
          dvd_q <= dvd_nx;
          rem_q <= rem_nx[DSW-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            cnt_q   <= '0;
            loss_q  <= lossv;
            lv_q    <= 1'b1;
            sum_q   <= '0;
            count_q <= '0;
            st_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_nd_q   <= nd_q;
      o_grad_q <= grad_q;
      o_loss_q <= loss_q;
      o_lv_q   <= lv_q;
    end
  end

  assign empty_o           = !ovalid_q;
  assign normalized_diff_o = o_nd_q;
  assign gradient_o        = o_grad_q;
  assign loss_value_o      = o_loss_q;
  assign loss_valid_o      = o_lv_q;

endmodule

@@ hw/rtl/bell_weighted_loss_accumulator.sv @@
`timescale 1ns / 1ps
// Bell-weighted loss accumulator. Push prediction/label pairs (signed fixed
// point, FRAC_BITS fraction bits) in; pop one result per pair: the
// normalised difference e / (1 + (|y| * inv_threshold)^power), the gradient
// and, on the beat marked last_element, the loss sum / (2 * count), after
// which the sum and count start again from zero. All results saturate.
// Each item holds the back end while it goes through the shared shift-add
// multiplier for |y| * inv_threshold and each power step, then the
// restoring divider, then the multiplier again for the gradient and the
// loss term; the last element takes a second divider pass for the loss.
// A two-entry queue lets the front take beats while the back end is busy,
// and the output register holds a finished beat while the next one is in
// work. Write the configuration registers only while the block is idle.
module bell_weighted_loss_accumulator #(
  parameter int unsigned DATA_WIDTH = blwa_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = blwa_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_POWER  = blwa_pkg::MAX_POWER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic signed [DATA_WIDTH-1:0]     prediction_i,
  input  logic signed [DATA_WIDTH-1:0]     label_i,
  input  logic                             last_element_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic signed [DATA_WIDTH-1:0]     normalized_diff_o,
  output logic signed [DATA_WIDTH-1:0]     gradient_o,
  output logic signed [DATA_WIDTH-1:0]     loss_value_o,
  output logic                             loss_valid_o,
  input  logic                             cfg_we_i,
  input  logic [blwa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DATA_WIDTH-1:0]            cfg_data_i
);
  import blwa_pkg::*;

  localparam int unsigned IW = 2 * DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] INV_RESET =
    {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic [DATA_WIDTH-1:0] inv_threshold_q, gradient_scale_q;
  logic [POWER_W-1:0]    power_q;
  logic                  q_push, q_pop;
  logic [IW-1:0]         q_wdata, q_rdata;
  qstat_t                q_stat;
  logic [DATA_WIDTH-1:0] nd, grad, loss;

  // Configuration: one write a beat, unknown indexes drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_threshold_q  <= INV_RESET;
      power_q          <= POWER_RESET;
      gradient_scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INV_THRESHOLD: inv_threshold_q  <= cfg_data_i;
        REG_POWER:         power_q          <= cfg_data_i[POWER_W-1:0];
        REG_GRAD_SCALE:    gradient_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: form the error and label magnitude, hand the beat to the queue
  blwa_front #(.DW(DATA_WIDTH)) u_front (
    .prediction_i   (prediction_i),
    .label_i        (label_i),
    .last_element_i (last_element_i),
    .push_i         (push_i),
    .full_o         (full_o),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  blwa_queue #(.W(IW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // Back: weight, divide, scale, accumulate, hold the result for the consumer
  blwa_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .MP(MAX_POWER)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .inv_threshold_i   (inv_threshold_q),
    .power_i           (power_q),
    .gradient_scale_i  (gradient_scale_q),
    .pop_i             (pop_i),
    .empty_o           (empty_o),
    .normalized_diff_o (nd),
    .gradient_o        (grad),
    .loss_value_o      (loss),
    .loss_valid_o      (loss_valid_o)
  );

  assign normalized_diff_o = nd;
  assign gradient_o        = grad;
  assign loss_value_o      = loss;

endmodule

@@ hw/rtl/blwa_checker.sv @@
`timescale 1ns / 1ps
`include "bell_weighted_loss_accumulator_macros.svh"
module blwa_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push_i,
  input logic                  full_o,
  input logic                  pop_i,
  input logic                  empty_o,
  input logic [DATA_WIDTH-1:0] normalized_diff_o,
  input logic [DATA_WIDTH-1:0] gradient_o,
  input logic [DATA_WIDTH-1:0] loss_value_o,
  input logic                  loss_valid_o
);

  logic [3:0] outst_q;
  logic       acc_in, acc_out;

  assign acc_in  = push_i && !full_o;
  assign acc_out = pop_i && !empty_o;

  // Beats taken in but not yet popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) outst_q <= 4'd0;
    else outst_q <= outst_q + {3'b000, acc_in} - {3'b000, acc_out};
  end

  `BLWA_ASSERT_RST(a_reset_quiet, !rst_ni |-> (empty_o && !full_o))
  `BLWA_ASSERT(a_no_invented, !empty_o |-> (outst_q != 4'd0))
  `BLWA_ASSERT(a_full_backlog, full_o |-> (outst_q >= 4'd2))
  `BLWA_ASSERT(a_loss_zero, (!empty_o && !loss_valid_o) |-> (loss_value_o == '0))
  `BLWA_ASSERT(a_hold, (!empty_o && !pop_i) |=> (!empty_o && $stable(normalized_diff_o) && $stable(gradient_o)))

endmodule

bind bell_weighted_loss_accumulator blwa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_blwa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .push_i            (push_i),
  .full_o            (full_o),
  .pop_i             (pop_i),
  .empty_o           (empty_o),
  .normalized_diff_o (normalized_diff_o),
  .gradient_o        (gradient_o),
  .loss_value_o      (loss_value_o),
  .loss_valid_o      (loss_valid_o)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import blwa_pkg::*;

  localparam int unsigned DW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned MAXP = 8;
  localparam logic [63:0] DMASK   = 64'hFFFF_FFFF;
  localparam logic [63:0] SMAXV   = 64'h7FFF_FFFF;
  localparam logic [63:0] SMINMAG = 64'h8000_0000;
  localparam logic [63:0] ONEQ    = 64'h1_0000;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;
  // The watchdog limit lies far above both the slowest beat and the long receiver hold.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 64;

  typedef struct {
    logic [DW-1:0] ndiff;
    logic [DW-1:0] grad;
    logic [DW-1:0] loss;
    logic          lvalid;
  } loss_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  logic                full_o;
  logic signed [DW-1:0] prediction_i;
  logic signed [DW-1:0] label_i;
  logic                last_element_i;
  logic                pop_i;
  logic                empty_o;
  logic signed [DW-1:0] normalized_diff_o;
  logic signed [DW-1:0] gradient_o;
  logic signed [DW-1:0] loss_value_o;
  logic                loss_valid_o;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DW-1:0]       cfg_data_i;

  bell_weighted_loss_accumulator uut (.*);

  // Predictor copy of the registers and the running state
  logic [DW-1:0]      inv_thr_q;
  logic [POWER_W-1:0] power_q;
  logic [DW-1:0]      gscale_q;
  logic [63:0]        err_sum_q;
  logic [63:0]        elem_cnt_q;

  loss_beat_t predicted_beats[$];
  int         mismatches = 0;
  bit         rx_hold;
  int         idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  // Unsigned fixed-point product: truncate, saturate at cap.
  function automatic logic [63:0] fx_mul_sat(input logic [63:0] a, b, cap);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    if (prod[127:64] != 0) return cap;
    prod = prod >> FB;
    return (prod[63:0] > cap) ? cap : prod[63:0];
  endfunction

  function automatic logic [DW-1:0] sat_pack(input logic neg, input logic [63:0] mag);
    logic [63:0] t;
    if (neg && mag != 0) begin
      if (mag > SMINMAG) mag = SMINMAG;
      t = ~mag + 64'd1;
      return t[DW-1:0];
    end
    return (mag > SMAXV) ? SMAXV[DW-1:0] : mag[DW-1:0];
  endfunction

  function automatic logic [63:0] magnitude(input logic [DW-1:0] v);
    logic [DW-1:0] n;
    n = ~v + 1'b1;
    return v[DW-1] ? {32'd0, n} : {32'd0, v};
  endfunction

  // Work out one result beat and advance the sum and count.
  function automatic loss_beat_t predict_loss_beat(input logic signed [DW-1:0] p, y,
                                                   input logic last);
    loss_beat_t  r;
    longint      ps, ys, e;
    logic [63:0] em, ym, gm, a, acc, w, q, rem, dm, gmag, term;
    logic        eneg, dneg, gneg;
    int          pw;
    ps = p;
    ys = y;
    e = ps - ys;
    eneg = e < 0;
    em = eneg ? 64'(-e) : 64'(e);
    ym = magnitude(y);
    gm = magnitude(gscale_q);
    gneg = gscale_q[DW-1];
    pw = (power_q > MAXP) ? MAXP : power_q;

    a = fx_mul_sat(ym, {32'd0, inv_thr_q}, DMASK);
    acc = ONEQ;
    for (int i = 0; i < pw; i++) acc = fx_mul_sat(acc, a, DMASK);
    w = ONEQ + acc;
    if (w > DMASK) w = DMASK;

    q = em / w;
    rem = em % w;
    if (q > (SMINMAG >> FB)) begin
      dm = SMINMAG + 1;
    end else begin
      for (int i = 0; i < FB; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= w) begin
          rem = rem - w;
          q[0] = 1'b1;
        end
      end
      dm = q;
    end
    dneg = eneg && dm != 0;
    r.ndiff = sat_pack(dneg, dm);
    if (dm > (dneg ? SMINMAG : SMAXV)) dm = dneg ? SMINMAG : SMAXV;

    gmag = fx_mul_sat(dm, gm, SMINMAG + 1);
    r.grad = sat_pack(dneg != gneg, gmag);

    term = fx_mul_sat(dm, em, SUM_MAX);
    err_sum_q = (err_sum_q > SUM_MAX - term) ? SUM_MAX : err_sum_q + term;
    if (elem_cnt_q < CNT_MAX) elem_cnt_q++;

    if (last) begin
      r.loss = sat_pack(1'b0, err_sum_q / (2 * elem_cnt_q));
      r.lvalid = 1'b1;
      err_sum_q = 0;
      elem_cnt_q = 0;
    end else begin
      r.loss = '0;
      r.lvalid = 1'b0;
    end
    return r;
  endfunction

  // Offer one beat after a random gap; hold push high afterwards so the
  // next beat can follow back to back.
  task automatic send_pair(input logic [DW-1:0] p, y, input logic last);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    prediction_i <= p;
    label_i <= y;
    last_element_i <= last;
    do @(posedge clk_i); while (full_o);
    predicted_beats.push_back(predict_loss_beat(p, y, last));
  endtask

  // Drop push and wait until every predicted beat has come out.
  task automatic drain;
    push_i <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all three registers while the block is idle.
  task automatic configure(input logic [DW-1:0] thr, input logic [POWER_W-1:0] pwr,
                           input logic [DW-1:0] gs);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_INV_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_index_i <= REG_POWER;
    cfg_data_i <= {{(DW - POWER_W){1'b0}}, pwr};
    @(posedge clk_i);
    cfg_index_i <= REG_GRAD_SCALE;
    cfg_data_i <= gs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    inv_thr_q = thr;
    power_q = pwr;
    gscale_q = gs;
  endtask

  // Mostly small magnitudes, so the weight stays in its interesting range.
  function automatic logic [DW-1:0] rand_word();
    logic [DW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0004_0000);
      2: v = $urandom >> $urandom_range(4, 20);
      3: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(0, 32'h0000_4000);
    endcase
    if ($urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  function automatic logic [DW-1:0] rand_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return ONEQ[DW-1:0];
      2: return $urandom;
      3: return $urandom_range(0, 32'h0004_0000);
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_blob(input int len);
    for (int i = 0; i < len; i++) send_pair(rand_word(), rand_word(), i == len - 1);
  endtask

  task automatic test_reset_defaults;
    send_pair(32'h0, 32'h0, 1'b1);
    send_pair(32'h0001_0000, 32'h0, 1'b0);
    send_pair(32'hFFFF_0000, 32'h0000_8000, 1'b1);
  endtask

  task automatic test_extremes;
    configure(ONEQ[DW-1:0], 4'd2, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h0000_0001, 1'b1);
  endtask

  task automatic test_power_edges;
    // power zero gives a fixed weight of two
    configure(ONEQ[DW-1:0], 4'd0, 32'hFFFF_0000);
    send_pair(32'h0003_0000, 32'h0001_0000, 1'b0);
    send_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
    // power above the clamp, widest threshold, weight saturates
    configure(32'hFFFF_FFFF, 4'd15, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h0000_0100, 1'b0);
    send_pair(32'h0000_0010, 32'h8000_0000, 1'b1);
    send_pair(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    // zero threshold: weight one plus zero
    configure(32'h0, 4'd8, 32'h0001_0000);
    send_pair(32'h1234_5678, 32'hEDCB_A988, 1'b0);
    send_pair(32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills up and raises full.
  task automatic test_backpressure;
    configure(ONEQ[DW-1:0], 4'd1, 32'h0002_0000);
    rx_hold = 1'b1;
    fork
      send_blob(10);
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join
  endtask

  task automatic test_random_blobs;
    int sent, len;
    for (int phase = 0; phase < 6; phase++) begin
      configure(rand_threshold(),
                ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 4)),
                ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                     : 32'h8000_0000)
                                            : rand_word());
      sent = 0;
      while (sent < 120) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
        send_blob(len);
        sent += len;
      end
    end
  endtask

  // Receiver: random gaps, a long hold on request, check each beat taken.
  initial begin
    int gap;
    loss_beat_t want;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) gap = 0;
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      while (rx_hold) begin
        pop_i <= 1'b0;
        @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      if (predicted_beats.size() == 0) begin
        $error("unexpected result beat");
        mismatches++;
      end else begin
        want = predicted_beats.pop_front();
        if (normalized_diff_o !== want.ndiff) begin
          $error("normalized_diff: expected %h, got %h", want.ndiff, normalized_diff_o);
          mismatches++;
        end
        if (gradient_o !== want.grad) begin
          $error("gradient: expected %h, got %h", want.grad, gradient_o);
          mismatches++;
        end
        if (loss_value_o !== want.loss) begin
          $error("loss_value: expected %h, got %h", want.loss, loss_value_o);
          mismatches++;
        end
        if (loss_valid_o !== want.lvalid) begin
          $error("loss_valid: expected %b, got %b", want.lvalid, loss_valid_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: reset on any accepted beat, give up after a long silence.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push_i = 1'b0;
    prediction_i = '0;
    label_i = '0;
    last_element_i = 1'b0;
    pop_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_INV_THRESHOLD;
    cfg_data_i = '0;
    rx_hold = 1'b0;
    inv_thr_q = ONEQ[DW-1:0];
    power_q = POWER_RESET;
    gscale_q = '0;
    err_sum_q = '0;
    elem_cnt_q = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extremes();
    test_power_edges();
    test_backpressure();
    test_random_blobs();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/blwa_pkg.sv
hw/rtl/blwa_queue.sv
hw/rtl/blwa_front.sv
hw/rtl/blwa_back.sv
hw/rtl/bell_weighted_loss_accumulator.sv
hw/rtl/blwa_checker.sv
verif/tb.sv
